[src/sngh_pkg.sv]
`timescale 1ns / 1ps
package sngh_pkg;
   localparam int unsigned IDX_W = 64;
   localparam int unsigned LEN_W = 3;

   // window geometry
   localparam int unsigned MAX_GRAM = 4;
   localparam int unsigned MAX_SKIP = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_GRAM_SIZE  = 2'd0;
   localparam logic [1:0] CSR_SKIP_LIMIT = 2'd1;
   localparam logic [1:0] CSR_HASH_MULT  = 2'd2;
   localparam logic [63:0] HASH_MULT_RESET = 64'd27942141;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_MUL,
      ST_ADD,
      ST_EMIT,
      ST_NEXT,
      ST_DONE
   } back_state_type;

   // one queued item
   typedef struct packed {
      logic [IDX_W-1:0] feature_index;
      logic             list_end;
   } queue_item_type;

   // configuration handed to the back part
   typedef struct packed {
      logic [2:0]       gram_size;
      logic [1:0]       skip_limit;
      logic [IDX_W-1:0] hash_multiplier;
   } cfg_type;
endpackage

[src/sngh_if.sv]
`timescale 1ns / 1ps
interface sngh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] feature_index;
   logic        list_end;
   modport source (output valid, feature_index, list_end, input ready);
   modport sink (input valid, feature_index, list_end, output ready);
endinterface

interface sngh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] gram_hash;
   logic [2:0]  gram_length;
   logic        run_last;
   modport source (output valid, gram_hash, gram_length, run_last, input ready);
   modport sink (input valid, gram_hash, gram_length, run_last, output ready);
endinterface

interface sngh_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/skip_ngram_feature_hasher_unit.sv]
`timescale 1ns / 1ps
// Skip n-gram feature hasher. Feature indices of a list arrive one item at a
// time; each index closes every gram of 2..gram_size elements that ends at it
// with total skip at most skip_limit, and one hashed result per gram leaves on
// rsp (h = h*multiplier + index, mod 2^64), run_last marking the item's final
// gram. A front stage takes items into a two-entry queue; the back sequencer
// walks skip patterns one at a time, and each gram element after the first
// costs a 64-bit multiply-add built from three 32x32 partial products. A full
// item at gram size 4 and skip 2 walks 19 grams and 20 rejected patterns.
// Configuration writes are always accepted and must only be issued while no
// item is in flight; there is no clearing pass after reset.
module skip_ngram_feature_hasher_unit
   import sngh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sngh_req_if.sink   req,
   sngh_rsp_if.source rsp,
   sngh_csr_if.sink   csr
);
   logic           fq_valid, fq_ready, qb_valid, qb_ready;
   queue_item_type fq_item, qb_item;
   cfg_type        cfg;

   sngh_front u_front (
      .clock, .reset, .req, .csr,
      .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item), .cfg
   );

   sngh_queue #(.DEPTH(2)) u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item)
   );

   sngh_back u_back (
      .clock, .reset,
      .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item), .cfg, .rsp
   );
endmodule

[src/sngh_queue.sv]
`timescale 1ns / 1ps
module sngh_queue
   import sngh_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  queue_item_type in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output queue_item_type out_item
);
   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   queue_item_type     mem_ff [DEPTH];
   logic [PW-1:0]      wr_ff, rd_ff;
   logic [PW:0]        cnt_ff;
   logic               push, pop;

   assign in_ready  = (cnt_ff != (PW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(DEPTH)) else $error("queue count overflow");
   no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == (PW+1)'(DEPTH)) |-> !push) else $error("push while full");
   no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !pop) else $error("pop while empty");
endmodule

[src/sngh_front.sv]
`timescale 1ns / 1ps
module sngh_front
   import sngh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   sngh_req_if.sink        req,
   sngh_csr_if.sink        csr,
   output logic            q_valid,
   input  logic            q_ready,
   output queue_item_type  q_item,
   output cfg_type         cfg
);
   logic [2:0]       gram_size_ff;
   logic [1:0]       skip_limit_ff;
   logic [IDX_W-1:0] hash_mult_ff;

   // pass items into the queue
   assign q_valid              = req.valid;
   assign req.ready            = q_ready;
   assign q_item.feature_index = req.feature_index;
   assign q_item.list_end      = req.list_end;

   // configuration registers, clamped later in the back part
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gram_size_ff  <= '0;
         skip_limit_ff <= '0;
         hash_mult_ff  <= HASH_MULT_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_GRAM_SIZE:  gram_size_ff  <= csr.data[2:0];
            CSR_SKIP_LIMIT: skip_limit_ff <= csr.data[1:0];
            CSR_HASH_MULT:  hash_mult_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   assign cfg.gram_size       = gram_size_ff;
   assign cfg.skip_limit      = skip_limit_ff;
   assign cfg.hash_multiplier = hash_mult_ff;
endmodule

[src/sngh_back.sv]
`timescale 1ns / 1ps
module sngh_back
   import sngh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   output logic           q_ready,
   input  queue_item_type q_item,
   input  cfg_type        cfg,
   sngh_rsp_if.source     rsp
);
   localparam int unsigned WIN  = MAX_GRAM + MAX_SKIP - 1;
   localparam int unsigned GAPS = MAX_GRAM - 1;
   localparam int unsigned SW   = $clog2(MAX_SKIP + 1) + 1;
   localparam int unsigned GW   = $clog2(MAX_GRAM + 1);
   localparam int unsigned OW   = $clog2(WIN + 1);
   localparam int unsigned TW   = $clog2(GAPS * MAX_SKIP + 1) + 1;
   localparam int unsigned EW   = $clog2(GAPS + 1);
   localparam int unsigned LW   = $clog2(MAX_GRAM + 1) + 1;
   localparam logic [1:0]  MUL_LAST = 2'd2;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] win_ff [WIN];
   logic [OW-1:0]    fill_ff;
   logic [IDX_W-1:0] cur_ff;
   logic             last_ff;
   logic [GW-1:0]    len_ff, gs;
   logic [SW-1:0]    sk;
   logic [SW-1:0]    sv_ff [GAPS];
   logic [EW-1:0]    step_ff;
   logic [OW-1:0]    off_ff;
   logic [IDX_W-1:0] h_ff, prod_ff;
   logic [1:0]       mph_ff;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_p;
   logic [IDX_W-1:0] out_hash_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic             out_last_ff, out_valid_ff;
   logic             pend_ff;
   logic             release_gram;
   logic [IDX_W-1:0] hold_hash_ff;
   logic [LEN_W-1:0] hold_len_ff;
   logic [TW-1:0]    total;
   logic [OW+TW-1:0] span;
   logic             fits;
   logic [GAPS:0]    carry;
   logic             pat_done, len_done;
   logic [IDX_W-1:0] elem;
   logic [OW-1:0]    next_off;

   // clamped configuration
   assign gs = (LW'(cfg.gram_size) > LW'(MAX_GRAM)) ? GW'(MAX_GRAM) : GW'(cfg.gram_size);
   assign sk = (SW'(cfg.skip_limit) > SW'(MAX_SKIP)) ? SW'(MAX_SKIP) : SW'(cfg.skip_limit);

   // total skip of the current pattern over the active gaps
   always_comb begin
      total = '0;
      for (int i = 0; i < GAPS; i++) begin
         if (LW'(i) < LW'(len_ff) - LW'(1)) total = total + TW'(sv_ff[i]);
      end
      span = (OW+TW)'(len_ff) - (OW+TW)'(1) + (OW+TW)'(total);
      fits = (total <= TW'(sk)) && (span <= (OW+TW)'(fill_ff));
   end

   // mixed-radix advance: carry out of the top active gap ends the length
   always_comb begin
      carry[0] = 1'b1;
      for (int i = 0; i < GAPS; i++) begin
         carry[i+1] = carry[i] && (sv_ff[i] >= sk);
      end
      pat_done = 1'b0;
      for (int i = 1; i <= GAPS; i++) begin
         if (len_ff == GW'(i + 1)) pat_done = carry[i];
      end
      len_done = (len_ff >= gs);
   end

   // element at distance off_ff back
   always_comb begin
      elem = cur_ff;
      for (int i = 0; i < WIN; i++) begin
         if (off_ff == OW'(i + 1)) elem = win_ff[i];
      end
   end
   assign next_off = off_ff - OW'(1) - OW'(sv_ff[step_ff]);

   // 32x32 partial products: low*low, then the two cross terms
   assign mul_a = (mph_ff == 2'd1) ? h_ff[63:32] : h_ff[31:0];
   assign mul_b = (mph_ff == MUL_LAST) ? cfg.hash_multiplier[63:32]
                                       : cfg.hash_multiplier[31:0];
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = (gs >= GW'(2)) ? ST_CHECK : ST_DONE;
         ST_CHECK: state_in = fits ? ST_LOAD : ST_NEXT;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL:   state_in = (mph_ff == MUL_LAST) ? ST_ADD : ST_MUL;
         ST_ADD:   state_in = (step_ff == EW'(len_ff - GW'(2))) ? ST_EMIT : ST_MUL;
         ST_EMIT:  if (!pend_ff) state_in = ST_NEXT;
         ST_NEXT:  state_in = (pat_done && len_done) ? ST_DONE : ST_CHECK;
         ST_DONE:  if (!pend_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs toward the queue
   always_comb begin
      q_ready = 1'b0;
      unique case (state_ff)
         ST_DONE: q_ready = !pend_ff;
         default: q_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cur_ff  <= q_item.feature_index;
            last_ff <= q_item.list_end;
            len_ff  <= GW'(2);
            for (int i = 0; i < GAPS; i++) sv_ff[i] <= '0;
         end
         ST_LOAD: begin
            h_ff    <= elem;
            off_ff  <= OW'(span);
            step_ff <= '0;
            mph_ff  <= '0;
         end
         ST_MUL: begin
            prod_ff <= (mph_ff == '0) ? mul_p : prod_ff + {mul_p[31:0], 32'd0};
            mph_ff  <= (mph_ff == MUL_LAST) ? '0 : mph_ff + 2'd1;
            if (mph_ff == MUL_LAST) off_ff <= next_off;
         end
         ST_ADD: begin
            h_ff    <= prod_ff + elem;
            step_ff <= step_ff + EW'(1);
         end
         ST_NEXT: begin
            if (pat_done) begin
               len_ff <= len_ff + GW'(1);
               for (int i = 0; i < GAPS; i++) sv_ff[i] <= '0;
            end else begin
               for (int i = 0; i < GAPS; i++) begin
                  if (carry[i]) sv_ff[i] <= carry[i+1] ? '0 : sv_ff[i] + SW'(1);
               end
            end
         end
         default: ;
      endcase
      if (state_ff == ST_CHECK) off_ff <= OW'(span);
   end

   // held gram waits for the next to decide run_last
   assign release_gram = pend_ff && !(out_valid_ff && !rsp.ready) &&
                         ((state_ff == ST_EMIT) || (state_ff == ST_DONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (release_gram)                out_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         if (release_gram)                pend_ff <= 1'b0;
         else if (state_ff == ST_EMIT)    pend_ff <= 1'b1;
      end
   end

   // output register, loaded from the hold buffer
   always_ff @(posedge clock) begin
      if (release_gram) begin
         out_hash_ff <= hold_hash_ff;
         out_len_ff  <= hold_len_ff;
         out_last_ff <= (state_ff == ST_DONE);
      end
   end

   // hold buffer
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && !pend_ff) begin
         hold_hash_ff <= h_ff;
         hold_len_ff  <= LEN_W'(len_ff);
      end
   end

   // window update at the end of the item
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < WIN; i++) win_ff[i] <= '0;
      end else if (state_ff == ST_DONE && !pend_ff) begin
         if (last_ff) begin
            fill_ff <= '0;
            for (int i = 0; i < WIN; i++) win_ff[i] <= '0;
         end else begin
            win_ff[0] <= cur_ff;
            for (int i = 1; i < WIN; i++) win_ff[i] <= win_ff[i-1];
            if (fill_ff < OW'(WIN)) fill_ff <= fill_ff + OW'(1);
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.gram_hash   = out_hash_ff;
   assign rsp.gram_length = out_len_ff;
   assign rsp.run_last    = out_last_ff;

   fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= OW'(WIN)) else $error("window fill beyond depth");
   len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (len_ff >= GW'(2) && len_ff <= gs))
      else $error("gram length out of range");
   take_done: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> (state_ff == ST_DONE && !pend_ff)) else $error("early take");
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.gram_hash) &&
      $stable(rsp.gram_length) && $stable(rsp.run_last)))
      else $error("result changed while waiting");
endmodule
